@@ hdl/pcrf_pkg.sv @@
// shared types and constants for the power converter register file
// no dependencies; imported by power_converter_register_file
package pcrf_pkg;

  localparam int unsigned NumRegsDefault = 16;

  localparam int unsigned DataW = 8;
  localparam int unsigned AddrW = 8;

  // command codes carried in tuser
  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  // fixed register addresses
  localparam logic [AddrW-1:0] AddrLimit  = 8'd2;
  localparam logic [AddrW-1:0] AddrMask   = 8'd5;
  localparam logic [AddrW-1:0] AddrMode   = 8'd6;
  localparam logic [AddrW-1:0] AddrStatus = 8'd7;

  localparam logic [DataW-1:0] LimitReset  = 8'h32;
  localparam logic [DataW-1:0] ModeReset   = 8'h20;
  localparam logic [DataW-1:0] StatusReset = 8'h03;

  localparam logic [DataW-1:0] FaultBits     = 8'hE0;
  localparam logic [DataW-1:0] FaultClrMask  = 8'h1F;
  localparam logic [DataW-1:0] PhaseClrMask  = 8'hFC;
  localparam logic [DataW-1:0] OvpBit        = 8'h20;
  localparam logic [DataW-1:0] OutEnableBit  = 8'h80;

  localparam logic [1:0] PhaseLast = 2'd2;

  function automatic logic [DataW-1:0] reg_reset_val(input int unsigned idx);
    logic [DataW-1:0] val;
    val = '0;
    if (idx == int'(AddrLimit)) val = LimitReset;
    if (idx == int'(AddrMode)) val = ModeReset;
    if (idx == int'(AddrStatus)) val = StatusReset;
    return val;
  endfunction

  function automatic logic fault_eval(input logic [DataW-1:0] status,
                                      input logic [DataW-1:0] mask);
    return |(status & mask & FaultBits);
  endfunction

endpackage

@@ hdl/power_converter_register_file.sv @@
// power converter register file: byte bus writes, reads and time ticks
// a transaction accepted on the slave side passes the input register, then the
// result register, before it is offered on the master side; throughput: one
// transaction per cycle unless the master side stalls (single-pass bank update)
// reset: asynchronous active low; bank returns to mode 0x20, status 0x03,
// limit 0x32, others zero; interrupt inactive, tick phase zero
module power_converter_register_file
  import pcrf_pkg::*;
#(
  parameter int unsigned NUM_REGS = NumRegsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] reg_address, [15:8] write_data
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [7:0] read_data, [8] int_pin_level, [15:9] zero
);

  localparam int unsigned IdxW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  // input register
  logic             in_vld_q;
  logic [AddrW-1:0] in_addr_q;
  logic [DataW-1:0] in_data_q;
  cmd_e             in_cmd_q;
  logic             in_last_q;

  // result register
  logic             out_vld_q;
  logic [DataW-1:0] out_rd_q;
  logic             out_pin_q;

  // state
  logic [DataW-1:0] regs_q [NUM_REGS];
  logic [DataW-1:0] regs_d [NUM_REGS];
  logic             fault_q, fault_d;
  logic [1:0]       phase_q, phase_d;
  logic [DataW-1:0] rd_d;

  logic             advance;
  logic             in_range;
  logic [IdxW-1:0]  idx;
  logic [DataW-1:0] status_cur, mask_cur, mode_cur, status_nxt, mask_nxt;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_addr_q <= s_axis_tdata[7:0];
      in_data_q <= s_axis_tdata[15:8];
      in_cmd_q  <= cmd_e'(s_axis_tuser);
      in_last_q <= s_axis_tlast;
    end
  end

  assign in_range   = {1'b0, in_addr_q} < 9'(NUM_REGS);
  assign idx        = in_addr_q[IdxW-1:0];
  assign status_cur = regs_q[AddrStatus[IdxW-1:0]];
  assign mask_cur   = regs_q[AddrMask[IdxW-1:0]];
  assign mode_cur   = regs_q[AddrMode[IdxW-1:0]];

  always_comb begin
    regs_d     = regs_q;
    fault_d    = fault_q;
    phase_d    = phase_q;
    rd_d       = '0;
    status_nxt = status_cur;
    mask_nxt   = mask_cur;
    unique case (in_cmd_q)
      CMD_WRITE: begin
        if (in_range && in_addr_q != AddrStatus) begin
          regs_d[idx] = in_data_q;
          if (in_addr_q == AddrMask) mask_nxt = in_data_q;
        end
        // interrupt only follows the mask on the final byte
        if (in_last_q) fault_d = fault_eval(status_cur, mask_nxt);
      end
      CMD_READ: begin
        if (in_range) begin
          rd_d = regs_q[idx];
          if (in_addr_q == AddrStatus) begin
            status_nxt = status_cur & FaultClrMask;
            regs_d[AddrStatus[IdxW-1:0]] = status_nxt;
            fault_d = fault_eval(status_nxt, mask_cur);
          end
        end
      end
      CMD_TICK: begin
        phase_d = (phase_q >= PhaseLast) ? 2'd0 : phase_q + 2'd1;
        if (phase_d == 2'd0 && (mode_cur & OutEnableBit) != '0) begin
          status_nxt = status_nxt | OvpBit;
        end
        status_nxt = (status_nxt & PhaseClrMask) | {6'd0, phase_d};
        regs_d[AddrStatus[IdxW-1:0]] = status_nxt;
        fault_d = fault_eval(status_nxt, mask_cur);
      end
      CMD_UNUSED: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_q[i] <= reg_reset_val(i);
      end
      fault_q <= 1'b0;
      phase_q <= 2'd0;
    end else if (advance) begin
      regs_q  <= regs_d;
      fault_q <= fault_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_rd_q  <= rd_d;
      out_pin_q <= !fault_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_pin_q, out_rd_q};

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// testbench for power_converter_register_file: byte writes, reads and ticks
// predicts every reply in a scoreboard class; depends on pcrf_pkg and the rtl
module tb_top
  import pcrf_pkg::*;
;

  localparam int unsigned NumRegs = NumRegsDefault;

  // register map and bit masks as the bus user sees them
  localparam logic [7:0] RegLimit  = 8'd2;
  localparam logic [7:0] RegMask   = 8'd5;
  localparam logic [7:0] RegMode   = 8'd6;
  localparam logic [7:0] RegStatus = 8'd7;
  localparam logic [7:0] FaultMask = 8'hE0;
  localparam logic [7:0] OvpFlag   = 8'h20;
  localparam logic [7:0] OutEnable = 8'h80;

  typedef struct packed {
    logic [7:0] read_data;
    logic       pin_level;
  } reply_t;

  class regfile_scoreboard;
    logic [7:0]  bank [NumRegs];
    logic        fault_on;
    logic [1:0]  phase;
    reply_t      expected_replies [$];
    int unsigned n_errors;
    int unsigned n_checked;
    int unsigned n_cmd [4];

    function new();
      for (int i = 0; i < NumRegs; i++) bank[i] = 8'h00;
      bank[RegMode]   = 8'h20;
      bank[RegStatus] = 8'h03;
      bank[RegLimit]  = 8'h32;
      fault_on  = 1'b0;
      phase     = 2'd0;
      n_errors  = 0;
      n_checked = 0;
      for (int i = 0; i < 4; i++) n_cmd[i] = 0;
    endfunction

    function void update_fault();
      fault_on = |(bank[RegStatus] & bank[RegMask] & FaultMask);
    endfunction

    // apply one accepted bus transaction and queue the reply it must produce
    function void note_access(cmd_e cmd, logic [7:0] addr, logic [7:0] wdata,
                              logic is_last);
      reply_t r;
      r.read_data = 8'h00;
      n_cmd[int'(cmd)]++;
      case (cmd)
        CMD_WRITE: begin
          if (addr < NumRegs && addr != RegStatus) bank[addr] = wdata;
          if (is_last) update_fault();
        end
        CMD_READ: begin
          if (addr < NumRegs) begin
            r.read_data = bank[addr];
            if (addr == RegStatus) begin
              bank[RegStatus] = bank[RegStatus] & ~FaultMask;
              update_fault();
            end
          end
        end
        CMD_TICK: begin
          phase = (phase == 2'd2) ? 2'd0 : phase + 2'd1;
          if (phase == 2'd0 && (bank[RegMode] & OutEnable) != 8'h00)
            bank[RegStatus] = bank[RegStatus] | OvpFlag;
          bank[RegStatus] = {bank[RegStatus][7:2], phase};
          update_fault();
        end
        default: ;
      endcase
      r.pin_level = ~fault_on;
      expected_replies.push_back(r);
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
      n_errors++;
      $display("tb_top: mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    endtask

    task check_reply(logic [15:0] got);
      reply_t want;
      if (expected_replies.size() == 0) begin
        report("reply with nothing outstanding", got, 16'h0000);
      end else begin
        want = expected_replies.pop_front();
        n_checked++;
        if (got[7:0] !== want.read_data)
          report("read_data", {8'h00, got[7:0]}, {8'h00, want.read_data});
        if (got[8] !== want.pin_level)
          report("int_pin_level", {15'h0, got[8]}, {15'h0, want.pin_level});
        if (got[15:9] !== 7'h00)
          report("tdata padding", {9'h0, got[15:9]}, 16'h0000);
      end
    endtask

    function int unsigned pending();
      return expected_replies.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = 16'h0000;  // [7:0] reg_address, [15:8] write_data
  logic [1:0]  s_axis_tuser = CMD_WRITE;  // [1:0] cmd
  logic        s_axis_tlast = 1'b0;      // last_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;             // [7:0] read_data, [8] int_pin_level

  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;

  regfile_scoreboard sb = new();

  power_converter_register_file #(
    .NUM_REGS(NumRegs)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready)
      sb.check_reply(m_axis_tdata);
  end

  task automatic send_access(cmd_e cmd, logic [7:0] addr, logic [7:0] wdata,
                             logic is_last);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {wdata, addr};
    s_axis_tuser  <= cmd;
    s_axis_tlast  <= is_last;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sb.note_access(cmd, addr, wdata, is_last);
  endtask

  task automatic send_random_access();
    cmd_e        cmd;
    logic [7:0]  addr;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) cmd = CMD_WRITE;
    else if (pick < 75) cmd = CMD_READ;
    else if (pick < 97) cmd = CMD_TICK;
    else cmd = CMD_UNUSED;
    // favor the mask, mode and status registers so faults come and go often
    pick = $urandom_range(9);
    if (pick < 4) begin
      case ($urandom_range(2))
        0: addr = RegMask;
        1: addr = RegMode;
        default: addr = RegStatus;
      endcase
    end else if (pick < 8) begin
      addr = 8'($urandom_range(NumRegs - 1));
    end else begin
      addr = 8'($urandom());
    end
    send_access(cmd, addr, 8'($urandom()), $urandom_range(4) != 0);
  endtask

  // hold the sender off until every reply is back, then let the pipe settle
  task automatic drain_replies();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    #(2_000_000);
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values, edges of the bank and out-of-range reads
    send_access(CMD_READ, RegStatus, 8'h00, 1'b0);
    send_access(CMD_READ, RegLimit, 8'h00, 1'b0);
    send_access(CMD_READ, RegMode, 8'h00, 1'b0);
    send_access(CMD_READ, 8'd0, 8'h00, 1'b1);
    send_access(CMD_READ, 8'(NumRegs - 1), 8'h00, 1'b0);
    send_access(CMD_READ, 8'(NumRegs), 8'h00, 1'b0);
    send_access(CMD_READ, 8'hFF, 8'h00, 1'b0);
    // enable output and unmask the faults, then tick until the phase wraps
    send_access(CMD_WRITE, RegMask, FaultMask, 1'b1);
    send_access(CMD_WRITE, RegMode, 8'hFF, 1'b1);
    send_access(CMD_TICK, 8'h00, 8'h00, 1'b0);
    send_access(CMD_TICK, 8'hFF, 8'hFF, 1'b1);
    send_access(CMD_TICK, 8'h00, 8'h00, 1'b0);
    // dropped status write, ignored high address, write without last byte
    send_access(CMD_WRITE, RegStatus, 8'hFF, 1'b1);
    send_access(CMD_WRITE, 8'hC8, 8'hAA, 1'b1);
    send_access(CMD_WRITE, RegMask, 8'h00, 1'b0);
    send_access(CMD_WRITE, 8'd3, 8'h55, 1'b1);
    send_access(CMD_WRITE, RegMask, 8'hFF, 1'b1);
    // status read hands back the flags and clears them
    send_access(CMD_READ, RegStatus, 8'h00, 1'b1);
    send_access(CMD_READ, RegStatus, 8'h00, 1'b0);
    send_access(CMD_UNUSED, RegStatus, 8'hFF, 1'b1);
    send_access(CMD_WRITE, 8'(NumRegs - 1), 8'hFF, 1'b1);
    send_access(CMD_READ, 8'(NumRegs - 1), 8'h00, 1'b0);
    send_access(CMD_WRITE, 8'hFF, 8'h00, 1'b0);
    send_access(CMD_READ, 8'd3, 8'h00, 1'b0);
    drain_replies();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 75; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 75; end
        default: begin src_idle_pct = 25; sink_stall_pct = 25; end
      endcase
      repeat (200) send_random_access();
      drain_replies();
    end

    if (sb.pending() != 0) sb.report("replies never returned", 16'(sb.pending()), 16'h0000);
    $display("tb_top: %0d transactions: %0d writes, %0d reads, %0d ticks, %0d unused",
             sb.n_cmd[0] + sb.n_cmd[1] + sb.n_cmd[2] + sb.n_cmd[3],
             sb.n_cmd[0], sb.n_cmd[1], sb.n_cmd[2], sb.n_cmd[3]);
    $display("tb_top: %0d replies checked over %s", sb.n_checked,
             "free-running, sender-idle, sink-stall and mixed phases");
    if (sb.n_errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/pcrf_pkg.sv
hdl/power_converter_register_file.sv
sim/tb_top.sv
